@@ design/rtfd_pkg.sv @@
// Shared types, constants and helper functions of the tag frame decoder.
`default_nettype none

package rtfd_pkg;

    localparam int READERS_DEF     = 2;
    localparam int FRAME_DEPTH_DEF = 14;
    localparam int KIND_W          = 2;
    localparam int POS_W           = 4;
    localparam int CNT_W           = 16;
    localparam int ID_W            = 64;

    typedef logic [7:0]        t_byte;
    typedef logic [KIND_W-1:0] t_kind;
    typedef logic [POS_W-1:0]  t_pos;
    typedef logic [15:0]       t_crc;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [ID_W-1:0]   t_id;

    typedef enum logic [1:0] {
        OP_BYTE    = 2'd0,
        OP_RUN     = 2'd1,
        OP_TIMEOUT = 2'd2,
        OP_NOP     = 2'd3
    } t_op;

    localparam t_kind KIND_FRONT = 2'd0;
    localparam t_kind KIND_LONG  = 2'd1;

    localparam t_byte LR_SOF   = 8'h54;
    localparam t_crc  CRC_MUL  = 16'd4225;
    localparam t_pos  FP_LAST  = 4'd12;
    localparam t_pos  FP_CHECK = 4'd13;
    localparam t_pos  FP_PRE   = 4'd4;
    localparam t_pos  LR_LAST  = 4'd9;
    localparam t_pos  LR_CHECK = 4'd10;
    localparam t_pos  LR_DATA  = 4'd8;

    // Per-reader framing context.
    typedef struct packed {
        t_pos  pos;
        t_byte xsum;
        t_crc  crc;
    } t_rd_ctx;

    typedef struct packed {
        t_rd_ctx nxt;
        logic    good;
        logic    bad;
        t_id     id;
    } t_dec_res;

    function automatic t_byte fp_prefix(input t_pos p);
        t_byte v;
        case (p)
            4'd0:    v = 8'h0E;
            4'd2:    v = 8'h11;
            4'd4:    v = 8'h05;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic logic [3:0] rev4(input logic [3:0] n);
        return {n[0], n[1], n[2], n[3]};
    endfunction

    function automatic t_crc crc_byte(input t_crc c, input t_byte b);
        t_crc v;
        v = (c >> 4) ^ (16'(c[3:0] ^ b[3:0]) * CRC_MUL);
        v = (v >> 4) ^ (16'(v[3:0] ^ b[7:4]) * CRC_MUL);
        return v;
    endfunction

endpackage

`default_nettype wire

@@ design/rtfd_req_if.sv @@
// Request channel carrying one received byte or event.
`default_nettype none

interface rtfd_req_if;
    import rtfd_pkg::*;

    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic       reader;
    t_byte      rx_byte;
    logic       framing_err;
    logic       parity_err;

    modport source (
        output valid, operation, reader, rx_byte, framing_err, parity_err,
        input  ready
    );
    modport sink (
        input  valid, operation, reader, rx_byte, framing_err, parity_err,
        output ready
    );
endinterface

`default_nettype wire

@@ design/rtfd_rsp_if.sv @@
// Result channel carrying one decode result per request.
`default_nettype none

interface rtfd_rsp_if;
    import rtfd_pkg::*;

    logic valid;
    logic ready;
    logic id_report;
    logic id_unknown;
    t_id  tag_id;
    logic frame_good;
    logic check_error;
    t_cnt framing_count;
    t_cnt parity_count;

    modport source (
        output valid, id_report, id_unknown, tag_id, frame_good, check_error,
               framing_count, parity_count,
        input  ready
    );
    modport sink (
        input  valid, id_report, id_unknown, tag_id, frame_good, check_error,
               framing_count, parity_count,
        output ready
    );
endinterface

`default_nettype wire

@@ design/rtfd_decode.sv @@
// Combinational frame decoder for one received byte of one reader.
`default_nettype none

module rtfd_decode
    import rtfd_pkg::*;
#(
    parameter int FRAME_DEPTH = FRAME_DEPTH_DEF
) (
    input  wire t_kind    i_kind,
    input  wire t_byte    i_byte,
    input  wire t_rd_ctx  i_ctx,
    input  wire t_byte    i_buf [FRAME_DEPTH],
    output t_dec_res      o_res
);

    t_byte x0;
    t_crc  c0;
    t_id   id_fp;
    t_id   id_lr;

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            id_fp[ID_W-1-8*i -: 8] = i_buf[12-i];
            id_lr[ID_W-1-8*i -: 4] = rev4(i_buf[1+i][3:0]);
            id_lr[ID_W-5-8*i -: 4] = rev4(i_buf[1+i][7:4]);
        end
    end

    always_comb begin
        o_res.nxt  = i_ctx;
        o_res.good = 1'b0;
        o_res.bad  = 1'b0;
        o_res.id   = '0;
        x0 = (i_ctx.pos == '0) ? '0 : i_ctx.xsum;
        c0 = (i_ctx.pos <= 4'd1) ? '0 : i_ctx.crc;
        case (i_kind)
            KIND_FRONT: begin
                if (i_ctx.pos <= FP_LAST) begin
                    o_res.nxt.xsum = x0;
                    if (i_ctx.pos <= FP_PRE && i_byte != fp_prefix(i_ctx.pos)) begin
                        o_res.nxt.pos = '0;
                    end else begin
                        o_res.nxt.xsum = x0 ^ i_byte;
                        o_res.nxt.pos  = i_ctx.pos + 4'd1;
                    end
                end else begin
                    if (i_ctx.pos == FP_CHECK) begin
                        if (i_byte == i_ctx.xsum) begin
                            o_res.good = 1'b1;
                            o_res.id   = id_fp;
                        end else begin
                            o_res.bad = 1'b1;
                        end
                    end
                    o_res.nxt.pos = '0;
                end
            end
            KIND_LONG: begin
                if (i_ctx.pos == '0 && i_byte != LR_SOF) begin
                    o_res.nxt.pos = '0;
                end else if (i_ctx.pos <= LR_LAST) begin
                    if (i_ctx.pos >= 4'd1 && i_ctx.pos <= LR_DATA) begin
                        o_res.nxt.crc = crc_byte(c0, i_byte);
                    end else begin
                        o_res.nxt.crc = c0;
                    end
                    o_res.nxt.pos = i_ctx.pos + 4'd1;
                end else begin
                    if (i_ctx.pos == LR_CHECK) begin
                        if ({i_byte, i_buf[9]} == i_ctx.crc) begin
                            o_res.good = 1'b1;
                            o_res.id   = id_lr;
                        end else begin
                            o_res.bad = 1'b1;
                        end
                    end
                    o_res.nxt.pos = '0;
                end
            end
            default: begin
                o_res.nxt.pos = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ design/rfid_tag_frame_decoder.sv @@
// Top level of the tag reader frame decoder: request staging, state and result register.
//
//   Channel  Dir  Handshake        Payload
//   i_req    in   valid / ready    operation, reader, rx_byte, framing_err, parity_err
//   o_rsp    out  valid / ready    id_report, id_unknown, tag_id, frame_good,
//                                  check_error, framing_count, parity_count
//   i_cfg    in   i_cfg_we         i_cfg_idx, i_cfg_data
//
// Each request yields exactly one result once it leaves the request register.
// One request per cycle is sustained while results are taken; the decode sits
// between the request register and the result register. Synchronous active-low
// reset clears the frame positions, sums, counters and the announce state. A
// stalled result holds the request register, and ready drops only while both are full.
`default_nettype none

module rfid_tag_frame_decoder
    import rtfd_pkg::*;
#(
    parameter int READERS     = READERS_DEF,
    parameter int FRAME_DEPTH = FRAME_DEPTH_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_we,
    input  wire         i_cfg_idx,
    input  wire t_kind  i_cfg_data,
    rtfd_req_if.sink    i_req,
    rtfd_rsp_if.source  o_rsp
);

    localparam int RIDX_W = (READERS > 1) ? $clog2(READERS) : 1;

    t_kind   r_kind [2];
    t_pos    r_pos  [READERS];
    t_byte   r_xsum [READERS];
    t_crc    r_crc  [READERS];
    t_cnt    r_fe   [READERS];
    t_cnt    r_pe   [READERS];
    t_byte   r_buf  [READERS][FRAME_DEPTH];
    t_id     r_last_id;
    logic    r_last_known;
    logic    r_armed;

    logic    r_in_vld;
    t_op     r_in_op;
    logic    r_in_reader;
    t_byte   r_in_byte;
    logic    r_in_fe;
    logic    r_in_pe;

    logic    r_out_vld;
    logic    r_out_rep;
    logic    r_out_unk;
    t_id     r_out_id;
    logic    r_out_good;
    logic    r_out_bad;
    t_cnt    r_out_fe;
    t_cnt    r_out_pe;

    logic              adv;
    logic              rd_ok;
    logic              is_byte;
    logic [RIDX_W-1:0] rd_idx;
    t_rd_ctx           ctx;
    t_dec_res          dec;
    t_cnt              n_fe;
    t_cnt              n_pe;
    logic              announce;
    logic              n_rep;
    logic              n_unk;

    assign adv         = r_in_vld && (!r_out_vld || o_rsp.ready);
    assign i_req.ready = !r_in_vld || adv;
    assign rd_idx      = RIDX_W'(r_in_reader);
    assign rd_ok       = 32'(r_in_reader) < READERS;
    assign is_byte     = rd_ok && (r_in_op == OP_BYTE);

    assign ctx.pos  = r_pos[rd_idx];
    assign ctx.xsum = r_xsum[rd_idx];
    assign ctx.crc  = r_crc[rd_idx];

    rtfd_decode #(
        .FRAME_DEPTH(FRAME_DEPTH)
    ) u_decode (
        .i_kind (r_kind[r_in_reader]),
        .i_byte (r_in_byte),
        .i_ctx  (ctx),
        .i_buf  (r_buf[rd_idx]),
        .o_res  (dec)
    );

    always_comb begin
        n_fe = r_fe[rd_idx];
        n_pe = r_pe[rd_idx];
        if (is_byte) begin
            n_fe = r_fe[rd_idx] + CNT_W'(r_in_fe);
            n_pe = r_pe[rd_idx] + CNT_W'(r_in_pe);
        end
        announce = is_byte && dec.good &&
                   (r_armed || !r_last_known || dec.id != r_last_id);
        n_rep = announce || (rd_ok && r_in_op == OP_TIMEOUT);
        n_unk = rd_ok && r_in_op == OP_TIMEOUT;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind[0] <= KIND_FRONT;
            r_kind[1] <= KIND_LONG;
        end else if (i_cfg_we) begin
            r_kind[i_cfg_idx] <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_req.ready) begin
            r_in_vld <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in_op     <= t_op'(i_req.operation);
            r_in_reader <= i_req.reader;
            r_in_byte   <= i_req.rx_byte;
            r_in_fe     <= i_req.framing_err;
            r_in_pe     <= i_req.parity_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int g = 0; g < READERS; g++) begin
                r_pos[g]  <= '0;
                r_xsum[g] <= '0;
                r_crc[g]  <= '0;
                r_fe[g]   <= '0;
                r_pe[g]   <= '0;
            end
            r_last_id    <= '0;
            r_last_known <= 1'b0;
            r_armed      <= 1'b0;
        end else if (adv) begin
            for (int g = 0; g < READERS; g++) begin
                if (is_byte && rd_idx == RIDX_W'(g)) begin
                    r_pos[g]  <= dec.nxt.pos;
                    r_xsum[g] <= dec.nxt.xsum;
                    r_crc[g]  <= dec.nxt.crc;
                    r_fe[g]   <= n_fe;
                    r_pe[g]   <= n_pe;
                end
            end
            if (rd_ok && r_in_op == OP_RUN) begin
                r_armed <= 1'b1;
            end else if (rd_ok && r_in_op == OP_TIMEOUT) begin
                r_last_known <= 1'b0;
            end else if (announce) begin
                r_armed      <= 1'b0;
                r_last_id    <= dec.id;
                r_last_known <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && is_byte) begin
            for (int g = 0; g < READERS; g++) begin
                for (int j = 0; j < FRAME_DEPTH; j++) begin
                    if (rd_idx == RIDX_W'(g) && {1'b0, ctx.pos} == 5'(j)) begin
                        r_buf[g][j] <= r_in_byte;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_rep  <= n_rep;
            r_out_unk  <= n_unk;
            r_out_good <= is_byte && dec.good;
            r_out_bad  <= is_byte && dec.bad;
            r_out_id   <= (is_byte && dec.good) ? dec.id : '0;
            r_out_fe   <= rd_ok ? n_fe : '0;
            r_out_pe   <= rd_ok ? n_pe : '0;
        end
    end

    assign o_rsp.valid         = r_out_vld;
    assign o_rsp.id_report     = r_out_rep;
    assign o_rsp.id_unknown    = r_out_unk;
    assign o_rsp.tag_id        = r_out_id;
    assign o_rsp.frame_good    = r_out_good;
    assign o_rsp.check_error   = r_out_bad;
    assign o_rsp.framing_count = r_out_fe;
    assign o_rsp.parity_count  = r_out_pe;

`ifndef ASSERT_OFF
    a_unk_reports: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out_unk |-> r_out_rep && !r_out_good)
        else $error("unknown ID result without a report");

    a_good_xor_bad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> !(r_out_good && r_out_bad))
        else $error("frame flagged both good and bad");

    a_id_needs_good: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !r_out_good |-> r_out_id == '0)
        else $error("tag ID shown without a good frame");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos[0] <= FP_CHECK)
        else $error("frame position out of range");
`endif

endmodule

`default_nettype wire

@@ verif/rfid_tag_frame_checker.sv @@
// Checker of the tag frame decoder: predicts each result from the accepted requests and compares.
`default_nettype none

module rfid_tag_frame_checker
    import rtfd_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_cfg_we,
    input  wire logic  i_cfg_idx,
    input  wire t_kind i_cfg_data,
    rtfd_req_if        req,
    rtfd_rsp_if        rsp,
    output int         o_pending,
    output int         o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int    FRAME_LEN      = 14;
    localparam t_byte FRONT_HDR [5]  = '{8'h0E, 8'h00, 8'h11, 8'h00, 8'h05};
    localparam t_crc  KERMIT_POLY    = 16'h8408;

    typedef struct packed {
        logic id_report;
        logic id_unknown;
        t_id  tag_id;
        logic frame_good;
        logic check_error;
        t_cnt framing_count;
        t_cnt parity_count;
    } t_tag_result;

    t_kind       reader_kind [2];
    t_pos        frame_pos [2];
    t_byte       frame_xor [2];
    t_crc        frame_crc [2];
    t_byte       frame_buf [2][FRAME_LEN];
    t_cnt        framing_cnt [2];
    t_cnt        parity_cnt [2];
    t_id         announced_id;
    logic        id_known;
    logic        run_armed;
    t_tag_result expected_q [$];
    t_tag_result new_res;
    t_tag_result want_res;
    int          fail_count = 0;

    function automatic t_crc kermit_update(input t_crc c, input t_byte b);
        t_crc v;
        v = c ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            v = v[0] ? ((v >> 1) ^ KERMIT_POLY) : (v >> 1);
        end
        return v;
    endfunction

    function automatic logic [3:0] mirror_nibble(input logic [3:0] n);
        logic [3:0] m;
        for (int k = 0; k < 4; k++) begin
            m[k] = n[3-k];
        end
        return m;
    endfunction

    function automatic logic offer_id(input t_id id);
        if (run_armed || !id_known || id != announced_id) begin
            run_armed    = 1'b0;
            announced_id = id;
            id_known     = 1'b1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic decode_request(input t_op op, input logic r, input t_byte b,
                                  input logic fe, input logic pe,
                                  output t_tag_result res);
        t_pos  pos;
        t_kind kind;
        t_id   id;
        res = '0;
        id  = '0;
        case (op)
            OP_RUN: begin
                run_armed = 1'b1;
            end
            OP_TIMEOUT: begin
                id_known       = 1'b0;
                res.id_report  = 1'b1;
                res.id_unknown = 1'b1;
            end
            OP_BYTE: begin
                pos  = frame_pos[r];
                kind = reader_kind[r];
                if (fe) framing_cnt[r] = framing_cnt[r] + 1'b1;
                if (pe) parity_cnt[r] = parity_cnt[r] + 1'b1;
                if (pos < FRAME_LEN) frame_buf[r][pos] = b;
                if (kind == KIND_FRONT) begin
                    if (pos <= FP_LAST) begin
                        if (pos == 0) frame_xor[r] = '0;
                        if (pos <= FP_PRE && b != FRONT_HDR[pos]) begin
                            frame_pos[r] = '0;
                        end else begin
                            frame_xor[r] = frame_xor[r] ^ b;
                            frame_pos[r] = pos + 1'b1;
                        end
                    end else begin
                        if (pos == FP_CHECK) begin
                            if (b == frame_xor[r]) begin
                                for (int i = 0; i < 8; i++) begin
                                    id = {id[55:0], frame_buf[r][FP_LAST - i]};
                                end
                                res.frame_good = 1'b1;
                                res.tag_id     = id;
                                res.id_report  = offer_id(id);
                            end else begin
                                res.check_error = 1'b1;
                            end
                        end
                        frame_pos[r] = '0;
                    end
                end else if (kind == KIND_LONG) begin
                    if (pos == 0 && b != LR_SOF) begin
                        frame_pos[r] = '0;
                    end else if (pos <= LR_LAST) begin
                        if (pos <= 1) frame_crc[r] = '0;
                        if (pos >= 1 && pos <= LR_DATA) begin
                            frame_crc[r] = kermit_update(frame_crc[r], b);
                        end
                        frame_pos[r] = pos + 1'b1;
                    end else begin
                        if (pos == LR_CHECK) begin
                            if ({frame_buf[r][LR_CHECK], frame_buf[r][LR_LAST]}
                                    == frame_crc[r]) begin
                                for (int i = 0; i < 8; i++) begin
                                    id = {id[55:0], mirror_nibble(frame_buf[r][1+i][3:0]),
                                          mirror_nibble(frame_buf[r][1+i][7:4])};
                                end
                                res.frame_good = 1'b1;
                                res.tag_id     = id;
                                res.id_report  = offer_id(id);
                            end else begin
                                res.check_error = 1'b1;
                            end
                        end
                        frame_pos[r] = '0;
                    end
                end else begin
                    frame_pos[r] = '0;
                end
            end
            default: ;
        endcase
        res.framing_count = framing_cnt[r];
        res.parity_count  = parity_cnt[r];
    endtask

    function automatic int field_differs(input string name, input logic [63:0] want,
                                         input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reader_kind  = '{KIND_FRONT, KIND_LONG};
            frame_pos    = '{default: '0};
            frame_xor    = '{default: '0};
            frame_crc    = '{default: '0};
            framing_cnt  = '{default: '0};
            parity_cnt   = '{default: '0};
            announced_id = '0;
            id_known     = 1'b0;
            run_armed    = 1'b0;
            expected_q.delete();
        end else begin
            if (i_cfg_we) reader_kind[i_cfg_idx] = i_cfg_data;
            if (rsp.valid && rsp.ready) begin
                if (expected_q.size() == 0) begin
                    $error("result arrived with no request outstanding");
                    fail_count++;
                end else begin
                    want_res = expected_q.pop_front();
                    fail_count += field_differs("id_report", want_res.id_report, rsp.id_report);
                    fail_count += field_differs("id_unknown", want_res.id_unknown,
                                                rsp.id_unknown);
                    fail_count += field_differs("tag_id", want_res.tag_id, rsp.tag_id);
                    fail_count += field_differs("frame_good", want_res.frame_good,
                                                rsp.frame_good);
                    fail_count += field_differs("check_error", want_res.check_error,
                                                rsp.check_error);
                    fail_count += field_differs("framing_count", want_res.framing_count,
                                                rsp.framing_count);
                    fail_count += field_differs("parity_count", want_res.parity_count,
                                                rsp.parity_count);
                end
            end
            if (req.valid && req.ready) begin
                decode_request(t_op'(req.operation), req.reader, req.rx_byte,
                               req.framing_err, req.parity_err, new_res);
                expected_q.push_back(new_res);
            end
        end
        o_pending    = expected_q.size();
        o_fail_count = fail_count;
    end

endmodule

`default_nettype wire

@@ verif/rfid_tag_frame_decoder_tb.sv @@
// Testbench top of the tag frame decoder: clock, reset, request and result traffic, verdict.
`default_nettype none

module rfid_tag_frame_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rtfd_pkg::*;

    localparam int    WATCHDOG_LIMIT = 2000;
    localparam int    LONG_HOLD      = 200;
    localparam int    PHASES         = 8;
    localparam int    PHASE_ITEMS    = 92;
    localparam int    DRAIN_PAUSE    = 4;
    localparam int    TAIL_CYCLES    = 10;
    localparam t_kind KIND_UNKNOWN   = 2'd2;
    localparam t_kind KIND_SPARE     = 2'd3;
    localparam t_byte FRONT_HDR [5]  = '{8'h0E, 8'h00, 8'h11, 8'h00, 8'h05};
    localparam t_kind PHASE_KIND0 [PHASES] = '{KIND_LONG, KIND_SPARE, KIND_FRONT, KIND_LONG,
                                               KIND_UNKNOWN, KIND_LONG, KIND_FRONT, KIND_FRONT};
    localparam t_kind PHASE_KIND1 [PHASES] = '{KIND_FRONT, KIND_UNKNOWN, KIND_FRONT, KIND_LONG,
                                               KIND_FRONT, KIND_SPARE, KIND_LONG, KIND_LONG};

    logic  i_clk;
    logic  i_rst_n;
    logic  cfg_we;
    logic  cfg_idx;
    t_kind cfg_data;
    int    pending;
    int    fail_count;
    int    idle_cycles = 0;
    int    items_sent = 0;
    int    results_taken = 0;
    int    rsp_hold;
    bit    sender_calm;
    bit    receiver_calm;
    t_kind kind_now [2];
    t_byte id_bytes [2][8];
    t_byte frame_q [2][$];

    rtfd_req_if req_if ();
    rtfd_rsp_if rsp_if ();

    rfid_tag_frame_decoder u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_req      (req_if),
        .o_rsp      (rsp_if)
    );

    rfid_tag_frame_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .req          (req_if),
        .rsp          (rsp_if),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    function automatic int draw_gap(input bit calm);
        if (calm || $urandom_range(0, 2) == 0) return 0;
        return $urandom_range(1, 16);
    endfunction

    task automatic push_request(input t_op op, input logic r, input t_byte b,
                                input logic fe, input logic pe);
        int gap;
        gap = draw_gap(sender_calm);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_if.valid       <= 1'b1;
        req_if.operation   <= op;
        req_if.reader      <= r;
        req_if.rx_byte     <= b;
        req_if.framing_err <= fe;
        req_if.parity_err  <= pe;
        do begin
            @(posedge i_clk);
        end while (!req_if.ready);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_byte(input logic r, input t_byte b);
        push_request(OP_BYTE, r, b, $urandom_range(0, 7) == 0, $urandom_range(0, 7) == 0);
    endtask

    // Appends one frame in the format the reader is set to; unknown formats get either one.
    task automatic build_frame(input int r, input bit fresh_id, input bit corrupt);
        t_kind k;
        t_byte chk;
        t_crc  crc;
        k = kind_now[r];
        if (k > KIND_LONG) k = t_kind'($urandom_range(0, 1));
        if (fresh_id) begin
            for (int i = 0; i < 8; i++) id_bytes[r][i] = t_byte'($urandom);
        end
        if (k == KIND_FRONT) begin
            chk = '0;
            for (int i = 0; i < 5; i++) begin
                frame_q[r].push_back(FRONT_HDR[i]);
                chk ^= FRONT_HDR[i];
            end
            for (int i = 0; i < 8; i++) begin
                frame_q[r].push_back(id_bytes[r][i]);
                chk ^= id_bytes[r][i];
            end
            if (corrupt) chk ^= t_byte'($urandom_range(1, 255));
            frame_q[r].push_back(chk);
        end else begin
            crc = '0;
            frame_q[r].push_back(LR_SOF);
            for (int i = 0; i < 8; i++) begin
                frame_q[r].push_back(id_bytes[r][i]);
                crc = crc_byte(crc, id_bytes[r][i]);
            end
            if (corrupt) crc ^= t_crc'($urandom_range(1, 16'hFFFF));
            frame_q[r].push_back(crc[7:0]);
            frame_q[r].push_back(crc[15:8]);
        end
    endtask

    task automatic flush_frames();
        int r;
        while (frame_q[0].size() + frame_q[1].size() > 0) begin
            if (frame_q[0].size() == 0) r = 1;
            else if (frame_q[1].size() == 0) r = 0;
            else r = $urandom_range(0, 1);
            send_byte(r[0], frame_q[r].pop_front());
        end
    endtask

    task automatic run_segment();
        int pick;
        int r;
        int idx;
        pick = $urandom_range(0, 99);
        r    = $urandom_range(0, 1);
        if (pick < 60) begin
            build_frame(r, $urandom_range(0, 3) != 0, $urandom_range(0, 9) == 0);
            if ($urandom_range(0, 3) == 0) begin
                build_frame(1 - r, $urandom_range(0, 3) != 0, $urandom_range(0, 9) == 0);
            end
            flush_frames();
        end else if (pick < 75) begin
            push_request(t_op'($urandom_range(1, 3)), r[0], t_byte'($urandom),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end else if (pick < 87) begin
            build_frame(r, 1'b1, 1'b0);
            idx = $urandom_range(0, frame_q[r].size() - 1);
            frame_q[r][idx] ^= t_byte'($urandom_range(1, 255));
            repeat ($urandom_range(0, 4)) void'(frame_q[r].pop_back());
            flush_frames();
        end else begin
            repeat ($urandom_range(1, 4)) send_byte(r[0], t_byte'($urandom));
        end
    endtask

    task automatic settle();
        req_if.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_PAUSE) @(negedge i_clk);
    endtask

    task automatic set_kinds(input t_kind k0, input t_kind k1);
        cfg_we   <= 1'b1;
        cfg_idx  <= 1'b0;
        cfg_data <= k0;
        @(negedge i_clk);
        cfg_idx  <= 1'b1;
        cfg_data <= k1;
        @(negedge i_clk);
        cfg_we   <= 1'b0;
        kind_now[0] = k0;
        kind_now[1] = k1;
    endtask

    initial begin
        rsp_if.ready  = 1'b0;
        receiver_calm = 1'b0;
        @(negedge i_clk);
        forever begin
            if (results_taken % 64 == 0) receiver_calm = ($urandom_range(0, 2) == 0);
            if (results_taken == 40 || results_taken == 450) rsp_hold = LONG_HOLD;
            else rsp_hold = draw_gap(receiver_calm);
            if (rsp_hold > 0) begin
                rsp_if.ready <= 1'b0;
                repeat (rsp_hold) @(negedge i_clk);
            end
            rsp_if.ready <= 1'b1;
            do begin
                @(posedge i_clk);
            end while (!rsp_if.valid);
            results_taken++;
            @(negedge i_clk);
        end
    end

    initial begin
        i_rst_n            = 1'b0;
        cfg_we             = 1'b0;
        cfg_idx            = 1'b0;
        cfg_data           = KIND_FRONT;
        req_if.valid       = 1'b0;
        req_if.operation   = OP_BYTE;
        req_if.reader      = 1'b0;
        req_if.rx_byte     = '0;
        req_if.framing_err = 1'b0;
        req_if.parity_err  = 1'b0;
        sender_calm        = 1'b0;
        kind_now           = '{KIND_FRONT, KIND_LONG};
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        set_kinds(KIND_FRONT, KIND_LONG);

        // Events, the ignored operation, both error flags and prefix mismatches on both formats.
        push_request(OP_NOP, 1'b0, 8'hFF, 1'b1, 1'b1);
        push_request(OP_TIMEOUT, 1'b1, 8'h00, 1'b0, 1'b0);
        push_request(OP_RUN, 1'b0, 8'h00, 1'b0, 1'b0);
        push_request(OP_BYTE, 1'b0, 8'hFF, 1'b1, 1'b0);
        push_request(OP_BYTE, 1'b1, 8'h00, 1'b0, 1'b1);
        id_bytes[0] = '{8'hFF, 8'h00, 8'h80, 8'h01, 8'hA5, 8'h5A, 8'h7F, 8'hFE};
        build_frame(0, 1'b0, 1'b0);
        flush_frames();
        push_request(OP_TIMEOUT, 1'b0, 8'h00, 1'b0, 1'b0);
        settle();

        for (int p = 0; p < PHASES; p++) begin
            set_kinds(PHASE_KIND0[p], PHASE_KIND1[p]);
            sender_calm = ($urandom_range(0, 3) == 0);
            while (items_sent < 20 + (p + 1) * PHASE_ITEMS) run_segment();
            // Leave both readers part way into a frame so the next format picks it up.
            build_frame(0, 1'b1, 1'b0);
            build_frame(1, 1'b1, 1'b0);
            repeat ($urandom_range(1, 10)) void'(frame_q[0].pop_back());
            repeat ($urandom_range(1, 10)) void'(frame_q[1].pop_back());
            flush_frames();
            settle();
        end

        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

`default_nettype wire
